// File: rtl/core/lfpe_pkg.sv
package lfpe_pkg;

  localparam int COEF_W      = 32;
  localparam int POW_W       = 6;
  localparam int FRAC_BITS   = 30;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;

  localparam logic [POW_W-1:0] MAX_FACTORS = 6'd63;
  localparam logic [POW_W-1:0] BS_RESET    = 6'd63;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD1,
    S_RD,
    S_MB,
    S_MA,
    S_WR,
    S_ERD,
    S_EOUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
  } mac_ctl_t;

endpackage

// File: rtl/core/linear_factor_product_expander.sv
// first factor of a block: accept (store of c0), then load of c1
// later factor onto n stored factors: RD, then MB, MA, WR per coefficient; one shared 32x32 MAC
// block close: ERD then EOUT per emitted coefficient (count+1 of them), EOUT held by output stall
// one item at a time; in_stall is high from acceptance until the item is done
// synchronous active-low reset clears control and sets block_size to 63; the store is not cleared
module linear_factor_product_expander (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lfpe_pkg::POW_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [lfpe_pkg::COEF_W-1:0] in_factor_q,
  input  logic signed [lfpe_pkg::COEF_W-1:0] in_factor_p,
  input  logic                               in_last_factor,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [lfpe_pkg::COEF_W-1:0] out_coefficient,
  output logic [lfpe_pkg::POW_W-1:0]         out_power,
  output logic                               out_block_end,
  output logic                               out_saturated
);

  lfpe_pkg::state_t state_r, state_nxt;

  logic [lfpe_pkg::POW_W-1:0]         bs_r;
  logic [lfpe_pkg::POW_W-1:0]         n_r, n_nxt;
  logic [lfpe_pkg::POW_W-1:0]         j_r, j_nxt;
  logic                               ovf_r, ovf_nxt;
  logic signed [lfpe_pkg::COEF_W-1:0] hold_r, hold_nxt;
  logic signed [lfpe_pkg::COEF_W-1:0] q_r, p_r;
  logic                               last_r;

  logic                               out_valid_r;
  logic signed [lfpe_pkg::COEF_W-1:0] out_coef_r;
  logic [lfpe_pkg::POW_W-1:0]         out_pow_r;
  logic                               out_end_r;
  logic                               out_sat_r;

  logic                               in_acc;
  logic                               out_load;
  logic [lfpe_pkg::POW_W-1:0]         limit;
  logic [lfpe_pkg::POW_W-1:0]         cnt_inc;
  logic signed [lfpe_pkg::COEF_W-1:0] b_val;

  logic                               st_we, st_re;
  logic [lfpe_pkg::ADDR_W-1:0]        st_waddr, st_raddr;
  logic [lfpe_pkg::COEF_W-1:0]        st_wdata, st_rdata;

  lfpe_pkg::mac_ctl_t                 mac_ctl;
  logic signed [lfpe_pkg::COEF_W-1:0] mul_x, mul_y, mac_coef;
  logic                               mac_sat;

  lfpe_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lfpe_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_x (mul_x),
    .mul_y (mul_y),
    .coef  (mac_coef),
    .sat   (mac_sat)
  );

  assign in_stall = (state_r != lfpe_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == lfpe_pkg::S_EOUT) && (!out_valid_r || !out_stall);
  assign cnt_inc  = n_r + 6'd1;
  assign b_val    = (j_r == '0) ? '0 : $signed(st_rdata);

  always_comb begin
    if (bs_r == '0) begin
      limit = 6'd1;
    end else if (bs_r > lfpe_pkg::MAX_FACTORS) begin
      limit = lfpe_pkg::MAX_FACTORS;
    end else begin
      limit = bs_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    ovf_nxt   = ovf_r;
    hold_nxt  = hold_r;
    st_we     = 1'b0;
    st_waddr  = j_r;
    st_wdata  = mac_coef;
    st_re     = 1'b0;
    st_raddr  = j_r;
    mac_ctl   = '0;
    mul_x     = b_val;
    mul_y     = p_r;
    case (state_r)
      lfpe_pkg::S_IDLE: begin
        if (in_acc) begin
          if (n_r == '0) begin
            st_we     = 1'b1;
            st_waddr  = '0;
            st_wdata  = in_factor_q;
            state_nxt = lfpe_pkg::S_LOAD1;
          end else begin
            state_nxt = lfpe_pkg::S_RD;
          end
        end
      end
      lfpe_pkg::S_LOAD1: begin
        st_we    = 1'b1;
        st_waddr = 6'd1;
        st_wdata = p_r;
        n_nxt    = 6'd1;
        ovf_nxt  = 1'b0;
        j_nxt    = '0;
        if (last_r || (6'd1 >= limit)) begin
          state_nxt = lfpe_pkg::S_ERD;
        end else begin
          state_nxt = lfpe_pkg::S_IDLE;
        end
      end
      lfpe_pkg::S_RD: begin
        st_re     = 1'b1;
        st_raddr  = n_r;
        j_nxt     = cnt_inc;
        hold_nxt  = '0;
        state_nxt = lfpe_pkg::S_MB;
      end
      lfpe_pkg::S_MB: begin
        mac_ctl.mul_en = 1'b1;
        mul_x          = b_val;
        mul_y          = p_r;
        state_nxt      = lfpe_pkg::S_MA;
      end
      lfpe_pkg::S_MA: begin
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        mul_x            = hold_r;
        mul_y            = q_r;
        state_nxt        = lfpe_pkg::S_WR;
      end
      lfpe_pkg::S_WR: begin
        st_we    = 1'b1;
        st_waddr = j_r;
        st_wdata = mac_coef;
        ovf_nxt  = ovf_r | mac_sat;
        hold_nxt = b_val;
        if (j_r == '0) begin
          n_nxt = cnt_inc;
          if (last_r || (cnt_inc >= limit)) begin
            state_nxt = lfpe_pkg::S_ERD;
          end else begin
            state_nxt = lfpe_pkg::S_IDLE;
          end
        end else begin
          // next coefficient needs the entry below it
          st_re     = (j_r >= 6'd2);
          st_raddr  = j_r - 6'd2;
          j_nxt     = j_r - 6'd1;
          state_nxt = lfpe_pkg::S_MB;
        end
      end
      lfpe_pkg::S_ERD: begin
        st_re     = 1'b1;
        st_raddr  = j_r;
        state_nxt = lfpe_pkg::S_EOUT;
      end
      lfpe_pkg::S_EOUT: begin
        if (out_load) begin
          if (j_r == n_r) begin
            n_nxt     = '0;
            ovf_nxt   = 1'b0;
            state_nxt = lfpe_pkg::S_IDLE;
          end else begin
            j_nxt     = j_r + 6'd1;
            state_nxt = lfpe_pkg::S_ERD;
          end
        end
      end
      default: begin
        state_nxt = lfpe_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfpe_pkg::S_IDLE;
      bs_r        <= lfpe_pkg::BS_RESET;
      n_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) begin
        bs_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    hold_r <= hold_nxt;
    if (in_acc) begin
      q_r    <= in_factor_q;
      p_r    <= in_factor_p;
      last_r <= in_last_factor;
    end
    if (out_load) begin
      out_coef_r <= st_rdata;
      out_pow_r  <= j_r;
      out_end_r  <= (j_r == n_r);
      out_sat_r  <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_power       = out_pow_r;
  assign out_block_end   = out_end_r;
  assign out_saturated   = out_sat_r;

  // every block holds at least two coefficients
  a_end_not_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_end |-> out_power != '0)
    else $error("block end on power zero");

  a_wr_after_ma: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == lfpe_pkg::S_WR |-> $past(state_r) == lfpe_pkg::S_MA)
    else $error("write-back without accumulate");

  a_fresh_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && n_r == '0 |=> state_r == lfpe_pkg::S_LOAD1)
    else $error("new block not loaded");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && j_r == n_r |=> state_r == lfpe_pkg::S_IDLE && n_r == '0 && out_block_end)
    else $error("block not closed after last coefficient");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lfpe_pkg::S_MB || state_r == lfpe_pkg::S_MA || state_r == lfpe_pkg::S_WR)
    |-> j_r <= cnt_inc)
    else $error("update index beyond top coefficient");

endmodule

// File: rtl/core/lfpe_store.sv
module lfpe_store (
  input  logic                               clk,
  input  logic                               we,
  input  logic [lfpe_pkg::ADDR_W-1:0]        waddr,
  input  logic [lfpe_pkg::COEF_W-1:0]        wdata,
  input  logic                               re,
  input  logic [lfpe_pkg::ADDR_W-1:0]        raddr,
  output logic [lfpe_pkg::COEF_W-1:0]        rdata
);

  logic [lfpe_pkg::COEF_W-1:0] mem [lfpe_pkg::STORE_DEPTH];
  logic [lfpe_pkg::COEF_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/lfpe_mac.sv
module lfpe_mac (
  input  logic                               clk,
  input  lfpe_pkg::mac_ctl_t                 ctl,
  input  logic signed [lfpe_pkg::COEF_W-1:0] mul_x,
  input  logic signed [lfpe_pkg::COEF_W-1:0] mul_y,
  output logic signed [lfpe_pkg::COEF_W-1:0] coef,
  output logic                               sat
);

  localparam int PROD_W = 2 * lfpe_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SH_W   = SUM_W - lfpe_pkg::FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]   sh;
  logic                     hi_same;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= mul_x * mul_y;
    end
    if (ctl.acc_load) begin
      acc_r <= prod_r;
    end
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    sum = {acc_r[PROD_W-1], acc_r} + {prod_r[PROD_W-1], prod_r}
          + (SUM_W'(1) <<< (lfpe_pkg::FRAC_BITS - 1));
    sh = sum[SUM_W-1:lfpe_pkg::FRAC_BITS];
    hi_same = (sh[SH_W-1:lfpe_pkg::COEF_W-1] == '0) ||
              (sh[SH_W-1:lfpe_pkg::COEF_W-1] == '1);
    sat = !hi_same;
    if (hi_same) begin
      coef = sh[lfpe_pkg::COEF_W-1:0];
    end else if (sh[SH_W-1]) begin
      coef = {1'b1, {(lfpe_pkg::COEF_W-1){1'b0}}};
    end else begin
      coef = {1'b0, {(lfpe_pkg::COEF_W-1){1'b1}}};
    end
  end

endmodule
